### rtl/u2w_pkg.sv
// ----------------------------------------------------------------------------
// u2w_pkg: shared types and encoding helpers for the UTF-16 to WTF-8 transcoder
// Holds the channel payload structs, the job descriptor that the front part
// hands to the back part, and the functions that build UTF-8 bytes.
// ----------------------------------------------------------------------------
package u2w_pkg;

	// Top six bits of a high surrogate (0xD800..0xDBFF) and a low one (0xDC00..0xDFFF).
	localparam logic [5:0] SURR_HI_TAG = 6'b110110;
	localparam logic [5:0] SURR_LO_TAG = 6'b110111;

	// Lead and continuation marks of UTF-8.
	localparam logic [7:0] LEAD1_MARK = 8'h00;
	localparam logic [7:0] LEAD2_MARK = 8'hC0;
	localparam logic [7:0] LEAD3_MARK = 8'hE0;
	localparam logic [7:0] LEAD4_MARK = 8'hF0;
	localparam logic [7:0] CONT_MARK  = 8'h80;

	// Limits of the one-, two- and three-byte forms.
	localparam logic [20:0] LIMIT1 = 21'h00080;
	localparam logic [20:0] LIMIT2 = 21'h00800;
	localparam logic [20:0] LIMIT3 = 21'h10000;

	// Added to the high surrogate bits, already shifted down by ten, to form 0x10000.
	localparam logic [10:0] PLANE_BASE = 11'd64;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        string_end;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_done;
	} out_t;

	// One request's work: an optional flushed lone high surrogate, then an
	// optional scalar. At least one of the two is present in every job.
	typedef struct packed {
		logic        has_pre;
		logic [9:0]  pre_bits;
		logic        has_main;
		logic [20:0] main_cp;
		logic        text_end;
	} job_t;

	// Number of UTF-8 bytes for a scalar, 1 to 4.
	function automatic logic [2:0] enc_len(input logic [20:0] cp);
		logic [2:0] len;
		if (cp < LIMIT1) begin
			len = 3'd1;
		end else if (cp < LIMIT2) begin
			len = 3'd2;
		end else if (cp < LIMIT3) begin
			len = 3'd3;
		end else begin
			len = 3'd4;
		end
		return len;
	endfunction

	// Byte number idx of the encoding of cp, whose length is len.
	function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] idx,
		input logic [2:0] len);
		logic [7:0] b;
		b = CONT_MARK | {2'b00, cp[5:0]};
		case (len)
			3'd1: begin
				b = LEAD1_MARK | {1'b0, cp[6:0]};
			end
			3'd2: begin
				if (idx == 2'd0) begin
					b = LEAD2_MARK | {3'b000, cp[10:6]};
				end
			end
			3'd3: begin
				case (idx)
					2'd0: b = LEAD3_MARK | {4'b0000, cp[15:12]};
					2'd1: b = CONT_MARK | {2'b00, cp[11:6]};
					default: b = CONT_MARK | {2'b00, cp[5:0]};
				endcase
			end
			default: begin
				case (idx)
					2'd0: b = LEAD4_MARK | {5'b00000, cp[20:18]};
					2'd1: b = CONT_MARK | {2'b00, cp[17:12]};
					2'd2: b = CONT_MARK | {2'b00, cp[11:6]};
					default: b = CONT_MARK | {2'b00, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

### rtl/u2w_front.sv
// ----------------------------------------------------------------------------
// u2w_front: request intake and surrogate pairing
// Classifies each code unit, keeps a pending high surrogate, and turns every
// accepted request into at most one job for the queue.
// ----------------------------------------------------------------------------
module u2w_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  u2w_pkg::in_t    in_item,
	output logic            job_valid,
	input  logic            job_ready,
	output u2w_pkg::job_t   job,
	output logic            held
);
	import u2w_pkg::*;

	logic       held_valid_q;
	logic [9:0] held_bits_q;
	logic       is_high;
	logic       is_low;
	logic       accept;
	logic       pair;
	logic       hold_next;

	assign is_high = (in_item.code_unit[15:10] == SURR_HI_TAG);
	assign is_low  = (in_item.code_unit[15:10] == SURR_LO_TAG);
	assign pair    = held_valid_q && is_low;
	assign hold_next = !pair && is_high && !in_item.string_end;

	always_comb begin
		job.text_end = in_item.string_end;
		if (pair) begin
			job.has_pre  = 1'b0;
			job.pre_bits = held_bits_q;
			job.has_main = 1'b1;
			job.main_cp  = {{1'b0, held_bits_q} + PLANE_BASE, in_item.code_unit[9:0]};
		end else begin
			job.has_pre  = held_valid_q;
			job.pre_bits = held_bits_q;
			job.has_main = !hold_next;
			job.main_cp  = {5'b00000, in_item.code_unit};
		end
	end

	assign in_ready  = job_ready;
	assign accept    = in_valid && in_ready;
	assign job_valid = in_valid && (job.has_pre || job.has_main);
	assign held      = held_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_bits_q  <= '0;
		end else if (accept) begin
			held_valid_q <= hold_next;
			held_bits_q  <= hold_next ? in_item.code_unit[9:0] : 10'd0;
		end
	end

endmodule

### rtl/u2w_queue.sv
// ----------------------------------------------------------------------------
// u2w_queue: job queue between front and back
// A small first-in first-out store of job descriptors.
// ----------------------------------------------------------------------------
module u2w_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  u2w_pkg::job_t   wr_job,
	output logic            rd_valid,
	input  logic            rd_ready,
	output u2w_pkg::job_t   rd_job
);
	import u2w_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/u2w_back.sv
// ----------------------------------------------------------------------------
// u2w_back: byte emitter that drives the registered output channel
// Walks each job one byte per cycle while the output channel is not stalled.
// ----------------------------------------------------------------------------
module u2w_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  u2w_pkg::job_t   job,
	output logic            out_valid,
	input  logic            out_ready,
	output u2w_pkg::out_t   out_item
);
	import u2w_pkg::*;

	job_t        cur_q;
	logic        busy_q;
	logic        seg_q;
	logic [1:0]  idx_q;
	logic        out_valid_q;
	out_t        out_q;
	logic [20:0] cp;
	logic [2:0]  len;
	logic        seg_last;
	logic        job_last;
	logic        adv;

	// The flushed segment is the lone high surrogate 0xD800 | bits.
	assign cp       = seg_q ? cur_q.main_cp : {5'b00000, SURR_HI_TAG, cur_q.pre_bits};
	assign len      = enc_len(cp);
	assign seg_last = (({1'b0, idx_q} + 3'd1) == len);
	assign job_last = seg_last && (seg_q || !cur_q.has_main);
	assign adv      = busy_q && (!out_valid_q || out_ready);
	assign job_ready = !busy_q || (adv && job_last);

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.out_byte  <= enc_byte(cp, idx_q, len);
			out_q.run_last  <= job_last;
			out_q.text_done <= job_last && cur_q.text_end;
		end
		if (job_ready && job_valid) begin
			cur_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			seg_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (job_ready) begin
				busy_q <= job_valid;
				seg_q  <= !job.has_pre;
				idx_q  <= '0;
			end else if (adv) begin
				if (seg_last) begin
					seg_q <= 1'b1;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

endmodule

### rtl/utf16_to_wtf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_to_wtf8_transcoder: UTF-16 code units in, WTF-8 bytes out
// Pairs surrogates into 4-byte sequences and writes unpaired surrogates as
// 3-byte sequences, one output byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake           | Payload (u2w_pkg)  | Moves per request
//   --------+---------------------+--------------------+----------------------
//   in      | in_valid/in_ready   | in_t  in_item      | one UTF-16 code unit
//   out     | out_valid/out_ready | out_t out_item     | one encoded byte
//
// The front part takes one request per cycle whenever the job queue has room.
// The back part emits one byte per cycle while the receiver is ready, so a
// request yields 1 to 4 bytes, or up to 6 when a held surrogate is flushed
// ahead of a unit; a high surrogate that gets held yields none. The output
// byte register sets the sustained rate. Reset clears the held surrogate,
// the queue and the output register. Either side may stall without stopping
// the other until the queue fills.
//
module utf16_to_wtf8_transcoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  u2w_pkg::in_t   in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output u2w_pkg::out_t  out_item
);
	import u2w_pkg::*;

	job_t wr_job;
	job_t rd_job;
	logic wr_valid;
	logic wr_ready;
	logic rd_valid;
	logic rd_ready;
	logic held;

	// Intake: classifies units and keeps the pending high surrogate.
	u2w_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.job_valid (wr_valid),
		.job_ready (wr_ready),
		.job       (wr_job),
		.held      (held)
	);

	// Decouples the intake from the byte port.
	u2w_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_job   (wr_job),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_job   (rd_job)
	);

	// Emits the bytes of each job in order.
	u2w_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (rd_valid),
		.job_ready (rd_ready),
		.job       (rd_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// The end of the string is only ever marked on the last byte of a unit.
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.text_done |-> out_item.run_last)
		else $error("text_done without run_last");

	// Nothing stays held once the final unit of a string is taken.
	a_end_clears_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.string_end |=> !held)
		else $error("surrogate still held after end of string");

	// A high surrogate that does not end the string is held for its partner.
	a_high_is_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_item.string_end
		&& in_item.code_unit[15:10] == SURR_HI_TAG |=> held)
		else $error("high surrogate not held");

endmodule

### sim/utf16_to_wtf8_transcoder_tb.sv
// ----------------------------------------------------------------------------
// utf16_to_wtf8_transcoder_tb: self-checking bench for the UTF-16 to WTF-8 transcoder
// Feeds directed and random UTF-16 strings through the block with random gaps
// on both channels. A byte tracker predicts the encoded bytes, and every byte
// that leaves the block is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module utf16_to_wtf8_transcoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u2w_pkg::*;

	// Least number of random code units to send after the directed part.
	localparam int RANDOM_UNITS = 206;
	// Byte count at which the receiver stops taking bytes for a long stretch.
	localparam int LONG_HOLD_AT = 150;
	localparam int LONG_HOLD_CYCLES = 400;
	// Unit count at which the sender waits for every predicted byte to drain.
	localparam int DRAIN_PAUSE_AT = 100;
	// Cycles to watch for stray bytes once nothing more is predicted.
	localparam int TAIL_CYCLES = 20;
	// Cycles without any handshake before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;

	// Surrogate ranges of UTF-16.
	localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;

	// Kinds of unit that the random string builder draws from.
	typedef enum int {
		UNIT_ASCII,
		UNIT_TWO_BYTE,
		UNIT_THREE_BYTE,
		UNIT_HIGH_SURR,
		UNIT_LOW_SURR,
		UNIT_ANY
	} unit_kind_e;

	// Tracks the held high surrogate and the WTF-8 bytes still owed by the block.
	class wtf8_byte_tracker;
		logic [9:0] held_bits;
		bit         held;
		out_t       bytes_due[$];
		int         fails;

		function new();
			held_bits = '0;
			held = 1'b0;
			fails = 0;
		endfunction

		function int pending();
			return bytes_due.size();
		endfunction

		function void add_byte(logic [7:0] value);
			out_t b;
			b.out_byte = value;
			b.run_last = 1'b0;
			b.text_done = 1'b0;
			bytes_due.insert(bytes_due.size(), b);
		endfunction

		// Appends the UTF-8 form of one scalar of at most 21 bits.
		function void add_scalar(logic [20:0] cp);
			if (cp < 21'h00080) begin
				add_byte({1'b0, cp[6:0]});
			end else if (cp < 21'h00800) begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end else if (cp < 21'h10000) begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end else begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
		endfunction

		// Called for every accepted request; queues the bytes it completes.
		function void take_unit(in_t req);
			int          first;
			logic        is_high;
			logic        is_low;
			logic [20:0] cp;
			first = bytes_due.size();
			is_high = req.code_unit >= HIGH_SURR_FIRST && req.code_unit <= HIGH_SURR_LAST;
			is_low = req.code_unit >= LOW_SURR_FIRST && req.code_unit <= LOW_SURR_LAST;
			if (held && is_low) begin
				cp = 21'h10000 + {1'b0, held_bits, 10'b0} + {5'b0, req.code_unit - LOW_SURR_FIRST};
				held = 1'b0;
				held_bits = '0;
				add_scalar(cp);
			end else begin
				if (held) begin
					add_scalar({5'b0, HIGH_SURR_FIRST[15:10], held_bits});
					held = 1'b0;
					held_bits = '0;
				end
				if (is_high && !req.string_end) begin
					held_bits = req.code_unit[9:0];
					held = 1'b1;
				end else begin
					add_scalar({5'b0, req.code_unit});
				end
			end
			if (bytes_due.size() > first) begin
				bytes_due[bytes_due.size() - 1].run_last = 1'b1;
				bytes_due[bytes_due.size() - 1].text_done = req.string_end;
			end
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $realtime, what);
			fails++;
		endtask

		// Called for every accepted byte; compares it with the oldest prediction.
		task check_byte(out_t got);
			out_t want;
			if (bytes_due.size() == 0) begin
				report($sformatf("byte %02h arrived with none predicted", got.out_byte));
			end else begin
				want = bytes_due.pop_front();
				if (got.out_byte !== want.out_byte) begin
					report($sformatf("out_byte %02h, wanted %02h", got.out_byte,
						want.out_byte));
				end
				if (got.run_last !== want.run_last) begin
					report($sformatf("run_last %b, wanted %b on byte %02h", got.run_last,
						want.run_last, want.out_byte));
				end
				if (got.text_done !== want.text_done) begin
					report($sformatf("text_done %b, wanted %b on byte %02h", got.text_done,
						want.text_done, want.out_byte));
				end
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_item;
	logic out_valid;
	logic out_ready;
	out_t out_item;

	wtf8_byte_tracker tracker;

	// Units of the string being sent, built ahead of sending.
	in_t text_units[$];
	// Bytes taken so far by the receiver.
	int  bytes_taken;
	int  idle_cycles;

	// Directed strings: the edges of every encoding length, surrogate pairs at
	// both ends of their ranges, lone low surrogates, a lone high surrogate at
	// the end of a string, a held surrogate flushed by plain text, a held
	// surrogate flushed by another high surrogate, and the six-byte case where
	// a held surrogate is flushed by a high surrogate that ends the string.
	logic [16:0] directed_units [24] = '{
		{16'h0000, 1'b0}, {16'h007F, 1'b0}, {16'h0080, 1'b0}, {16'h07FF, 1'b0},
		{16'h0800, 1'b0}, {16'hD7FF, 1'b0}, {16'hE000, 1'b0}, {16'hFFFF, 1'b0},
		{16'hD800, 1'b0}, {16'hDC00, 1'b0},
		{16'hDBFF, 1'b0}, {16'hDFFF, 1'b1},
		{16'hDC00, 1'b0}, {16'hDFFF, 1'b1},
		{16'hD800, 1'b1},
		{16'hDABC, 1'b0}, {16'h0041, 1'b0},
		{16'hD801, 1'b0}, {16'hDBFE, 1'b0}, {16'hDB00, 1'b1},
		{16'hD912, 1'b0}, {16'h00E9, 1'b1},
		{16'hD834, 1'b0}, {16'hDD1E, 1'b1}
	};

	utf16_to_wtf8_transcoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both channels are sampled at the rising edge, where the values driven at
	// the previous falling edge are stable. A request is predicted before any
	// byte of the same edge is checked, in case the block passes one straight
	// through.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				tracker.take_unit(in_item);
			end
			if (out_valid && out_ready) begin
				tracker.check_byte(out_item);
			end
		end
	end

	// The watchdog counts cycles in which neither channel moves anything. The
	// longest legal quiet stretch is the receiver's long hold with a full queue.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic in_t make_unit(logic [15:0] code, logic last);
		in_t u;
		u.code_unit = code;
		u.string_end = last;
		return u;
	endfunction

	function automatic void queue_unit(in_t u);
		text_units.insert(text_units.size(), u);
	endfunction

	function automatic logic [15:0] draw_code(unit_kind_e kind);
		logic [15:0] code;
		case (kind)
			UNIT_ASCII: code = 16'($urandom_range(16'h0000, 16'h007F));
			UNIT_TWO_BYTE: code = 16'($urandom_range(16'h0080, 16'h07FF));
			UNIT_THREE_BYTE: begin
				// Non-surrogate three-byte units sit on either side of the surrogates.
				if ($urandom_range(0, 1) == 0) begin
					code = 16'($urandom_range(16'h0800, 16'hD7FF));
				end else begin
					code = 16'($urandom_range(16'hE000, 16'hFFFF));
				end
			end
			UNIT_HIGH_SURR: code = 16'($urandom_range(HIGH_SURR_FIRST, HIGH_SURR_LAST));
			UNIT_LOW_SURR: code = 16'($urandom_range(LOW_SURR_FIRST, LOW_SURR_LAST));
			default: code = 16'($urandom_range(16'h0000, 16'hFFFF));
		endcase
		return code;
	endfunction

	// Builds one random string into text_units. Most positions are well formed
	// text, proper surrogate pairs included; the rest are lone surrogates and
	// raw 16-bit noise, which exercise the flush paths. Only the final unit
	// carries string_end.
	task automatic build_string();
		int positions;
		int pick;
		positions = $urandom_range(1, 8);
		text_units.delete();
		for (int i = 0; i < positions; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 6) begin
				queue_unit(make_unit(draw_code(UNIT_ASCII), 1'b0));
			end else if (pick < 8) begin
				queue_unit(make_unit(draw_code(UNIT_TWO_BYTE), 1'b0));
			end else if (pick < 10) begin
				queue_unit(make_unit(draw_code(UNIT_THREE_BYTE), 1'b0));
			end else if (pick < 15) begin
				queue_unit(make_unit(draw_code(UNIT_HIGH_SURR), 1'b0));
				queue_unit(make_unit(draw_code(UNIT_LOW_SURR), 1'b0));
			end else if (pick < 16) begin
				queue_unit(make_unit(draw_code(UNIT_HIGH_SURR), 1'b0));
			end else if (pick < 17) begin
				queue_unit(make_unit(draw_code(UNIT_LOW_SURR), 1'b0));
			end else begin
				queue_unit(make_unit(draw_code(UNIT_ANY), 1'b0));
			end
		end
		text_units[text_units.size() - 1].string_end = 1'b1;
	endtask

	// Offers one request after a gap of idle cycles and returns just after the
	// rising edge at which it was accepted. in_valid is only lowered when there
	// is a gap, so back-to-back requests keep it high without a glitch.
	task automatic send_unit(in_t unit, int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= unit;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// Receiver: takes bytes with random stalls, in phases that are chosen at random
	// between stalling and taking a byte every cycle. Once, it holds off for a
	// long stretch so that the queue fills and the block stops taking requests.
	initial begin
		bit long_hold_done;
		bit rx_burst;
		int gap;
		long_hold_done = 1'b0;
		rx_burst = 1'b0;
		bytes_taken = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (bytes_taken % 32 == 0) begin
				rx_burst = $urandom_range(0, 2) == 0;
			end
			if (!long_hold_done && bytes_taken == LONG_HOLD_AT) begin
				gap = LONG_HOLD_CYCLES;
				long_hold_done = 1'b1;
			end else if (rx_burst) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 10);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!out_valid);
			bytes_taken++;
		end
	end

	// Sender and end of run.
	initial begin
		int  units_sent;
		bit  tx_burst;
		bit  drained_once;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		tracker = new();
		units_sent = 0;
		drained_once = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_units[i]) begin
			send_unit(in_t'(directed_units[i]), $urandom_range(0, 10));
		end

		while (units_sent < RANDOM_UNITS) begin
			build_string();
			// Some strings go out back to back, the rest with random gaps.
			tx_burst = $urandom_range(0, 3) == 0;
			if (!drained_once && units_sent >= DRAIN_PAUSE_AT) begin
				// Let the block run completely dry before the next string.
				@(negedge clk);
				in_valid <= 1'b0;
				while (tracker.pending() != 0) @(negedge clk);
				drained_once = 1'b1;
			end
			foreach (text_units[i]) begin
				send_unit(text_units[i], tx_burst ? 0 : $urandom_range(0, 10));
				units_sent++;
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// The watchdog bounds this wait; the tail catches any stray extra bytes.
		while (tracker.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### sim.f
rtl/u2w_pkg.sv
rtl/u2w_front.sv
rtl/u2w_queue.sv
rtl/u2w_back.sv
rtl/utf16_to_wtf8_transcoder.sv
sim/utf16_to_wtf8_transcoder_tb.sv
